@@ rtl/mpd_pkg.sv @@
// ----------------------------------------------------------------------------
// mpd_pkg : shared types and constants of the multilevel priority dispatcher
// Queue geometry, field widths, operation and result codes, and the command
// and status bundles passed between controller and datapath.
// ----------------------------------------------------------------------------
package mpd_pkg;

	localparam int QUEUE_DEPTH = 256;
	localparam int MAX_CPUS    = 8;
	localparam int LEVELS      = 4;

	localparam int PTR_W     = $clog2(QUEUE_DEPTH);
	localparam int FILL_W    = $clog2(QUEUE_DEPTH + 1);
	localparam int LIDX_W    = $clog2(LEVELS);
	localparam int SIDX_W    = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
	localparam int CNT_W     = $clog2(MAX_CPUS + 1);
	localparam int ADDR_W    = LIDX_W + PTR_W;
	localparam int MEM_DEPTH = LEVELS * QUEUE_DEPTH;

	localparam int OP_W    = 2;
	localparam int JOB_W   = 16;
	localparam int PRIO_W  = 3;
	localparam int SLOT_W  = 3;
	localparam int KIND_W  = 3;
	localparam int LEVEL_W = 3;
	localparam int CFG_W   = 4;

	localparam logic [CFG_W-1:0] CPUS_RESET = CFG_W'(1);

	typedef enum logic [OP_W-1:0] {
		OP_SUBMIT   = 2'd0,
		OP_DISPATCH = 2'd1,
		OP_SLICE    = 2'd2,
		OP_NONE     = 2'd3
	} op_t;

	typedef enum logic [KIND_W-1:0] {
		K_ACCEPT   = 3'd0,
		K_DISPATCH = 3'd1,
		K_IDLE     = 3'd2,
		K_RETIRE   = 3'd3,
		K_REQUEUE  = 3'd4,
		K_FULL     = 3'd5
	} kind_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;     // latch the input word, clear the round count
		logic submit;     // push submitted job, emit its result
		logic slice;      // handle slice report, emit its result
		logic pop;        // claim lowest free slot, read head of top queue
		logic emit_disp;  // emit dispatched job, mark slot busy
		logic emit_idle;  // emit idle result of an empty round
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		op_t  op;         // latched operation
		logic found;      // another job can be dispatched this round
		logic pend_last;  // pending dispatch is the last of the round
		logic out_free;   // output register can take a word this cycle
	} status_t;

endpackage

@@ rtl/mpd_ctrl.sv @@
// ----------------------------------------------------------------------------
// mpd_ctrl : sequencing controller
// One-hot state machine that takes one input word at a time and steps the
// datapath through submit, slice report or a dispatch round.
// ----------------------------------------------------------------------------
module mpd_ctrl
	import mpd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  status_t st,
	output cmd_t    cmd
);

	typedef enum logic [6:0] {
		S_IDLE    = 7'b0000001,
		S_DECODE  = 7'b0000010,
		S_SUBMIT  = 7'b0000100,
		S_SLICE   = 7'b0001000,
		S_DSEARCH = 7'b0010000,
		S_DREAD   = 7'b0100000,
		S_DIDLE   = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (st.op)
					OP_SUBMIT:   state_d = S_SUBMIT;
					OP_DISPATCH: state_d = S_DSEARCH;
					OP_SLICE:    state_d = S_SLICE;
					OP_NONE:     state_d = S_IDLE;
					default:     state_d = S_IDLE;
				endcase
			end
			S_SUBMIT: begin
				if (st.out_free) begin
					cmd.submit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_SLICE: begin
				if (st.out_free) begin
					cmd.slice = 1'b1;
					state_d   = S_IDLE;
				end
			end
			S_DSEARCH: begin
				if (st.found) begin
					cmd.pop = 1'b1;
					state_d = S_DREAD;
				end else begin
					state_d = S_DIDLE;
				end
			end
			S_DREAD: begin
				if (st.out_free) begin
					cmd.emit_disp = 1'b1;
					state_d       = st.pend_last ? S_IDLE : S_DSEARCH;
				end
			end
			S_DIDLE: begin
				if (st.out_free) begin
					cmd.emit_idle = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ rtl/mpd_datapath.sv @@
// ----------------------------------------------------------------------------
// mpd_datapath : queues, running slots and output register
// Holds the ready-queue store and pointers, the running slots, the round
// size register and the registered result word.
// ----------------------------------------------------------------------------
module mpd_datapath
	import mpd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CFG_W-1:0]   cfg_data,
	input  logic [OP_W-1:0]    operation,
	input  logic [JOB_W-1:0]   job_id,
	input  logic [PRIO_W-1:0]  priority_req,
	input  logic [SLOT_W-1:0]  slot,
	input  logic               finished,
	input  cmd_t               cmd,
	output status_t            st,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [KIND_W-1:0]  kind,
	output logic [JOB_W-1:0]   job_id_out,
	output logic [SLOT_W-1:0]  slot_out,
	output logic [LEVEL_W-1:0] level_out,
	output logic               last
);

	// configuration and latched input word
	logic [CFG_W-1:0]  cpus_q;
	op_t               op_q;
	logic [JOB_W-1:0]  job_q;
	logic [PRIO_W-1:0] prio_q;
	logic [SLOT_W-1:0] slot_q;
	logic              fin_q;

	// queues
	logic [JOB_W-1:0]  mem [MEM_DEPTH];
	logic [JOB_W-1:0]  rd_data_q;
	logic [PTR_W-1:0]  head_q [LEVELS];
	logic [PTR_W-1:0]  tail_q [LEVELS];
	logic [FILL_W-1:0] fill_q [LEVELS];

	// running slots
	logic [MAX_CPUS-1:0] busy_q;
	logic [JOB_W-1:0]    sjob_q [MAX_CPUS];
	logic [LIDX_W-1:0]   slev_q [MAX_CPUS];

	// dispatch round
	logic [CNT_W-1:0]  cnt_q;
	logic [SIDX_W-1:0] pend_slot_q;
	logic [LIDX_W-1:0] pend_lidx_q;
	logic              pend_last_q;

	// output register
	logic               out_valid_q;
	logic [KIND_W-1:0]  kind_q;
	logic [JOB_W-1:0]   job_out_q;
	logic [SLOT_W-1:0]  slot_out_q;
	logic [LEVEL_W-1:0] level_out_q;
	logic               last_q;

	logic [LIDX_W-1:0]   sub_lidx, sl_lidx, push_lidx, sel_lidx;
	logic [SIDX_W-1:0]   sidx, free_slot;
	logic [LEVELS-1:0]   nonempty, others;
	logic [MAX_CPUS-1:0] free;
	logic                any_ne, any_free, more_slots, more_jobs;
	logic                slot_ok, push_full, do_push, last_pred, out_free, emit;
	logic [CNT_W-1:0]    lim;
	logic [ADDR_W-1:0]   waddr, raddr;
	logic [JOB_W-1:0]    wdata;
	logic [KIND_W-1:0]   kind_d;
	logic [JOB_W-1:0]    job_d;
	logic [SLOT_W-1:0]   slot_d;
	logic [LEVEL_W-1:0]  level_d;
	logic                last_d;

	assign cfg_ready = 1'b1;

	// level of a submitted job: own queue for 2..LEVELS, else level 1
	assign sub_lidx = (int'(prio_q) >= 2 && int'(prio_q) <= LEVELS)
		? LIDX_W'(int'(prio_q) - 1) : '0;

	assign sidx    = SIDX_W'(slot_q);
	assign slot_ok = (int'(slot_q) < MAX_CPUS) && busy_q[sidx];
	assign sl_lidx = slev_q[sidx];

	assign push_lidx = cmd.submit ? sub_lidx : sl_lidx;
	assign push_full = (fill_q[push_lidx] == FILL_W'(QUEUE_DEPTH));
	assign do_push   = (cmd.submit || (cmd.slice && slot_ok && !fin_q)) && !push_full;
	assign waddr     = {push_lidx, tail_q[push_lidx]};
	assign wdata     = cmd.submit ? job_q : sjob_q[sidx];

	// most urgent non-empty queue
	always_comb begin
		sel_lidx = '0;
		for (int l = LEVELS - 1; l >= 0; l--) begin
			nonempty[l] = (fill_q[l] != '0);
			if (nonempty[l]) sel_lidx = LIDX_W'(l);
		end
	end

	// lowest free slot
	always_comb begin
		free_slot = '0;
		for (int s = MAX_CPUS - 1; s >= 0; s--) begin
			free[s] = !busy_q[s];
			if (free[s]) free_slot = SIDX_W'(s);
		end
	end

	assign any_ne     = |nonempty;
	assign any_free   = |free;
	assign more_slots = |(free & (free - MAX_CPUS'(1)));
	assign others     = nonempty & ~(LEVELS'(1) << sel_lidx);
	assign more_jobs  = (fill_q[sel_lidx] > FILL_W'(1)) || (|others);
	assign raddr      = {sel_lidx, head_q[sel_lidx]};

	// round size: zero acts as one, clamp to slot count
	assign lim = (cpus_q == '0) ? CNT_W'(1)
		: (int'(cpus_q) > MAX_CPUS) ? CNT_W'(MAX_CPUS) : CNT_W'(cpus_q);

	assign last_pred = !(more_slots && more_jobs && (int'(cnt_q) + 1 < int'(lim)));

	assign out_free = !out_valid_q || !out_stall;
	assign emit     = cmd.submit || cmd.slice || cmd.emit_disp || cmd.emit_idle;

	assign st.op        = op_q;
	assign st.found     = any_free && any_ne && (cnt_q < lim);
	assign st.pend_last = pend_last_q;
	assign st.out_free  = out_free;

	// result word
	always_comb begin
		kind_d  = K_IDLE;
		job_d   = '0;
		slot_d  = '0;
		level_d = '0;
		last_d  = 1'b1;
		if (cmd.submit) begin
			kind_d  = do_push ? K_ACCEPT : K_FULL;
			job_d   = job_q;
			level_d = LEVEL_W'(int'(sub_lidx) + 1);
		end else if (cmd.slice) begin
			slot_d = slot_q;
			if (slot_ok) begin
				job_d   = sjob_q[sidx];
				level_d = LEVEL_W'(int'(sl_lidx) + 1);
				if (fin_q) kind_d = K_RETIRE;
				else       kind_d = push_full ? K_FULL : K_REQUEUE;
			end
		end else if (cmd.emit_disp) begin
			kind_d  = K_DISPATCH;
			job_d   = rd_data_q;
			slot_d  = SLOT_W'(pend_slot_q);
			level_d = LEVEL_W'(int'(pend_lidx_q) + 1);
			last_d  = pend_last_q;
		end
	end

	// queue store: one write and one registered read port
	always_ff @(posedge clk) begin
		if (do_push) mem[waddr] <= wdata;
		if (cmd.pop) rd_data_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < LEVELS; l++) begin
				head_q[l] <= '0;
				tail_q[l] <= '0;
				fill_q[l] <= '0;
			end
		end else begin
			for (int l = 0; l < LEVELS; l++) begin
				if (do_push && push_lidx == LIDX_W'(l)) begin
					tail_q[l] <= (int'(tail_q[l]) == QUEUE_DEPTH - 1) ? '0 : tail_q[l] + 1'b1;
					fill_q[l] <= fill_q[l] + 1'b1;
				end
				if (cmd.pop && sel_lidx == LIDX_W'(l)) begin
					head_q[l] <= (int'(head_q[l]) == QUEUE_DEPTH - 1) ? '0 : head_q[l] + 1'b1;
					fill_q[l] <= fill_q[l] - 1'b1;
				end
			end
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpus_q      <= CPUS_RESET;
			op_q        <= OP_NONE;
			busy_q      <= '0;
			cnt_q       <= '0;
			pend_last_q <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) cpus_q <= cfg_data;
			if (cmd.accept) begin
				op_q  <= op_t'(operation);
				cnt_q <= '0;
			end
			if (cmd.pop) pend_last_q <= last_pred;
			if (cmd.emit_disp) begin
				busy_q[pend_slot_q] <= 1'b1;
				cnt_q               <= cnt_q + 1'b1;
			end
			if (cmd.slice && slot_ok) busy_q[sidx] <= 1'b0;
			if (emit)            out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			job_q  <= job_id;
			prio_q <= priority_req;
			slot_q <= slot;
			fin_q  <= finished;
		end
		if (cmd.pop) begin
			pend_slot_q <= free_slot;
			pend_lidx_q <= sel_lidx;
		end
		if (cmd.emit_disp) begin
			sjob_q[pend_slot_q] <= rd_data_q;
			slev_q[pend_slot_q] <= pend_lidx_q;
		end
		if (emit) begin
			kind_q      <= kind_d;
			job_out_q   <= job_d;
			slot_out_q  <= slot_d;
			level_out_q <= level_d;
			last_q      <= last_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign kind       = kind_q;
	assign job_id_out = job_out_q;
	assign slot_out   = slot_out_q;
	assign level_out  = level_out_q;
	assign last       = last_q;

endmodule

@@ rtl/multilevel_priority_dispatcher.sv @@
// ----------------------------------------------------------------------------
// multilevel_priority_dispatcher : strict-priority multilevel job dispatcher
// Four FIFO ready queues feeding up to eight running slots, with submit,
// dispatch-round and slice-report operations.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid / in_stall): one word per operation. A word is
//   taken when in_valid is high and in_stall is low; the block works on one
//   word at a time and holds in_stall high until the word's last result is
//   in the output register.
//   Output channel (out_valid / out_stall): one word per result; last marks
//   the final result of an input word. The output register holds its word
//   while out_stall is high, and the next input word may be taken meanwhile.
//   Configuration (cfg_valid / cfg_ready): cfg_ready is always high; write
//   cpus_in_use only while the block is idle.
// Sequence
//   Submit and slice report: the word is decoded, then the result is registered
//   as soon as the output register is free; the next word is taken after that.
//   Dispatch round: paced by the single read port of the queue store, with one
//   head read, then one registered result per job; an empty round gives its
//   idle result after the search finds nothing to dispatch.
//   A stalled receiver holds back each result until the output register is free.
// Reset
//   Queue pointers and fill counts clear, all slots empty, cpus_in_use = 1.
//   The queue store needs no clearing pass; the block is ready at once.
// ----------------------------------------------------------------------------
module multilevel_priority_dispatcher
	import mpd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CFG_W-1:0]   cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [OP_W-1:0]    operation,
	input  logic [JOB_W-1:0]   job_id,
	input  logic [PRIO_W-1:0]  priority_req,
	input  logic [SLOT_W-1:0]  slot,
	input  logic               finished,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [KIND_W-1:0]  kind,
	output logic [JOB_W-1:0]   job_id_out,
	output logic [SLOT_W-1:0]  slot_out,
	output logic [LEVEL_W-1:0] level_out,
	output logic               last
);

	cmd_t    cmd;  // controller orders to the datapath
	status_t st;   // datapath conditions back to the controller

	// sequence each word: decode, then submit, slice or dispatch loop
	mpd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	// queues, slots and the output register
	mpd_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.operation    (operation),
		.job_id       (job_id),
		.priority_req (priority_req),
		.slot         (slot),
		.finished     (finished),
		.cmd          (cmd),
		.st           (st),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.job_id_out   (job_id_out),
		.slot_out     (slot_out),
		.level_out    (level_out),
		.last         (last)
	);

endmodule

@@ rtl/mpd_checker.sv @@
// ----------------------------------------------------------------------------
// mpd_checker : port-level checks of the dispatcher
// Watches the top-level ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module mpd_checker
	import mpd_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic [KIND_W-1:0]  kind,
	input logic [JOB_W-1:0]   job_id_out,
	input logic [SLOT_W-1:0]  slot_out,
	input logic [LEVEL_W-1:0] level_out,
	input logic               last
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kind) && $stable(job_id_out)
			&& $stable(slot_out) && $stable(level_out) && $stable(last))
		else $error("stalled result word changed");

	// one word at a time: stall straight after taking a word
	a_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while a word is in progress");

	// only defined result codes
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> kind <= KIND_W'(K_FULL))
		else $error("undefined result kind");

	// idle results carry no job and no level
	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_W'(K_IDLE) |-> job_id_out == '0 && level_out == '0)
		else $error("idle result with job or level");

	// job results name a real queue level
	a_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_W'(K_IDLE) |-> level_out != '0)
		else $error("job result without a level");

endmodule

bind multilevel_priority_dispatcher mpd_checker u_mpd_checker (.*);
